// ===== design/point_rotate_about_origin_core_macros.svh =====
// assertion helpers for the point rotation core
`ifndef POINT_ROTATE_ABOUT_ORIGIN_CORE_MACROS_SVH
`define POINT_ROTATE_ABOUT_ORIGIN_CORE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define PRA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pra assertion failed");

// next-cycle implication, sampled on clk_i, off while in reset
`define PRA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pra assertion failed");

`endif

// ===== design/pra_pkg.sv =====
package pra_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned AngleW = 20;
  localparam int unsigned OffW   = 33;
  localparam int unsigned ZW     = 35;
  localparam int unsigned CzW    = 34;
  localparam int unsigned GainW  = 31;
  localparam int unsigned XW     = 51;
  localparam int unsigned RndW   = 35;
  localparam int unsigned SumW   = 36;
  localparam int unsigned AtanW  = 30;
  localparam int unsigned AtanLen = 32;

  // angles in radians, Q.30
  localparam logic signed [ZW-1:0] AngPi     = 35'sd3373259426;
  localparam logic signed [ZW-1:0] AngTwoPi  = 35'sd6746518852;
  localparam logic signed [ZW-1:0] AngHalfPi = 35'sd1686629713;

  // cordic gain 0.60725293 in Q.30
  localparam logic signed [GainW-1:0] GainQ30 = 31'sd652032874;

  localparam logic signed [XW-1:0] RoundHalf = 51'sd32768;

  localparam logic signed [SumW-1:0] SatMax = 36'sh07FFFFFFF;
  localparam logic signed [SumW-1:0] SatMin = -36'sh080000000;

  // atan(2^-i) in Q.30, truncated
  localparam logic [AtanW-1:0] AtanQ30 [AtanLen] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6,
    30'h03FEAB76, 30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55,
    30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF,
    30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
    30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008,
    30'h00000004, 30'h00000002, 30'h00000001, 30'h00000000
  };

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] centre_x;
    logic signed [CoordW-1:0] centre_y;
    logic signed [AngleW-1:0] turn_angle;
  } in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] rotated_x;
    logic signed [CoordW-1:0] rotated_y;
    logic                     clipped;
  } out_t;

  // what one cordic cell hands to the next
  typedef struct packed {
    logic signed [XW-1:0]     x;
    logic signed [XW-1:0]     y;
    logic signed [CzW-1:0]    z;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
  } cell_t;

endpackage

// ===== design/pra_cell.sv =====
module pra_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  pra_pkg::cell_t cell_i,
  output logic          valid_o,
  output pra_pkg::cell_t cell_o
);
  import pra_pkg::*;

  logic signed [XW-1:0]  xs;
  logic signed [XW-1:0]  ys;
  logic signed [CzW-1:0] atan;
  logic                  valid_q;
  cell_t                 cell_d;
  cell_t                 cell_q;

  assign xs   = cell_i.x >>> STAGE;
  assign ys   = cell_i.y >>> STAGE;
  assign atan = $signed({{(CzW-AtanW){1'b0}}, AtanQ30[STAGE]});

  always_comb begin
    cell_d = cell_i;
    if (!cell_i.z[CzW-1]) begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - atan;
    end else begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

// ===== design/pra_prep.sv =====
module pra_prep (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  pra_pkg::in_t   data_i,
  output logic           valid_o,
  output pra_pkg::cell_t cell_o
);
  import pra_pkg::*;

  // stage 1: offset and angle reduction
  logic signed [ZW-1:0]     z_raw;
  logic signed [ZW-1:0]     z1_d;
  logic signed [OffW-1:0]   dx1_d;
  logic signed [OffW-1:0]   dy1_d;
  logic                     v1_q;
  logic signed [ZW-1:0]     z1_q;
  logic signed [OffW-1:0]   dx1_q;
  logic signed [OffW-1:0]   dy1_q;
  logic signed [CoordW-1:0] cx1_q;
  logic signed [CoordW-1:0] cy1_q;

  // stage 2: quadrant fold
  logic signed [ZW-1:0]     z2_d;
  logic signed [OffW-1:0]   dx2_d;
  logic signed [OffW-1:0]   dy2_d;
  logic                     v2_q;
  logic signed [CzW-1:0]    z2_q;
  logic signed [OffW-1:0]   dx2_q;
  logic signed [OffW-1:0]   dy2_q;
  logic signed [CoordW-1:0] cx2_q;
  logic signed [CoordW-1:0] cy2_q;

  // stage 3: gain
  logic signed [OffW+GainW-1:0] prod_x;
  logic signed [OffW+GainW-1:0] prod_y;
  logic                         v3_q;
  cell_t                        cell_q;

  assign z_raw = $signed({{(ZW-AngleW-14){data_i.turn_angle[AngleW-1]}},
                          data_i.turn_angle, 14'b0});

  assign dx1_d = $signed({data_i.point_x[CoordW-1], data_i.point_x})
               - $signed({data_i.centre_x[CoordW-1], data_i.centre_x});
  assign dy1_d = $signed({data_i.point_y[CoordW-1], data_i.point_y})
               - $signed({data_i.centre_y[CoordW-1], data_i.centre_y});

  always_comb begin
    z1_d = z_raw;
    if (z_raw > AngPi) begin
      z1_d = z_raw - AngTwoPi;
    end else if (z_raw <= -AngPi) begin
      z1_d = z_raw + AngTwoPi;
    end
  end

  // fold into the right half plane, turning the offset by pi
  always_comb begin
    z2_d  = z1_q;
    dx2_d = dx1_q;
    dy2_d = dy1_q;
    if (z1_q > AngHalfPi) begin
      z2_d  = z1_q - AngPi;
      dx2_d = -dx1_q;
      dy2_d = -dy1_q;
    end else if (z1_q < -AngHalfPi) begin
      z2_d  = z1_q + AngPi;
      dx2_d = -dx1_q;
      dy2_d = -dy1_q;
    end
  end

  assign prod_x = dx2_q * GainQ30;
  assign prod_y = dy2_q * GainQ30;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z1_q      <= z1_d;
      dx1_q     <= dx1_d;
      dy1_q     <= dy1_d;
      cx1_q     <= data_i.centre_x;
      cy1_q     <= data_i.centre_y;
      z2_q      <= z2_d[CzW-1:0];
      dx2_q     <= dx2_d;
      dy2_q     <= dy2_d;
      cx2_q     <= cx1_q;
      cy2_q     <= cy1_q;
      cell_q.x  <= XW'(prod_x >>> 14);
      cell_q.y  <= XW'(prod_y >>> 14);
      cell_q.z  <= z2_q;
      cell_q.cx <= cx2_q;
      cell_q.cy <= cy2_q;
    end
  end

  assign valid_o = v3_q;
  assign cell_o  = cell_q;

endmodule

// ===== design/pra_post.sv =====
module pra_post (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  pra_pkg::cell_t cell_i,
  output logic           valid_o,
  output pra_pkg::out_t  data_o
);
  import pra_pkg::*;

  logic signed [XW-1:0]     rx_sum;
  logic signed [XW-1:0]     ry_sum;
  logic                     v1_q;
  logic signed [RndW-1:0]   rx1_q;
  logic signed [RndW-1:0]   ry1_q;
  logic signed [CoordW-1:0] cx1_q;
  logic signed [CoordW-1:0] cy1_q;
  logic signed [SumW-1:0]   sx;
  logic signed [SumW-1:0]   sy;
  logic                     hit_x;
  logic                     hit_y;
  out_t                     out_d;
  logic                     out_valid_q;
  out_t                     out_q;

  assign rx_sum = cell_i.x + RoundHalf;
  assign ry_sum = cell_i.y + RoundHalf;

  assign sx = $signed({rx1_q[RndW-1], rx1_q})
            + $signed({{(SumW-CoordW){cx1_q[CoordW-1]}}, cx1_q});
  assign sy = $signed({ry1_q[RndW-1], ry1_q})
            + $signed({{(SumW-CoordW){cy1_q[CoordW-1]}}, cy1_q});

  always_comb begin
    hit_x = 1'b0;
    hit_y = 1'b0;
    out_d.rotated_x = sx[CoordW-1:0];
    out_d.rotated_y = sy[CoordW-1:0];
    if (sx > SatMax) begin
      out_d.rotated_x = SatMax[CoordW-1:0];
      hit_x = 1'b1;
    end else if (sx < SatMin) begin
      out_d.rotated_x = SatMin[CoordW-1:0];
      hit_x = 1'b1;
    end
    if (sy > SatMax) begin
      out_d.rotated_y = SatMax[CoordW-1:0];
      hit_y = 1'b1;
    end else if (sy < SatMin) begin
      out_d.rotated_y = SatMin[CoordW-1:0];
      hit_y = 1'b1;
    end
    out_d.clipped = hit_x | hit_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      v1_q        <= valid_i;
      out_valid_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx1_q <= RndW'(rx_sum >>> 16);
      ry1_q <= RndW'(ry_sum >>> 16);
      cx1_q <= cell_i.cx;
      cy1_q <= cell_i.cy;
      out_q <= out_d;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

// ===== design/point_rotate_about_origin_core.sv =====
// Rotates a point about a center by a signed Q4.16 radian angle and returns the
// saturated Q16.16 result with a clipped flag. The datapath is a fixed pipeline:
// three setup stages (offset and angle reduction, quadrant fold, gain multiply),
// a chain of ROTATION_STAGES cordic cells, and two output stages (rounding, then
// center add and saturation). One request is accepted every cycle; all stages
// advance together and hold only while the output register is full and not taken.
module point_rotate_about_origin_core #(
  parameter int unsigned ROTATION_STAGES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pra_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pra_pkg::out_t out_data_o
);
  import pra_pkg::*;

  logic                     en;
  logic [ROTATION_STAGES:0] chain_v;
  cell_t                    chain [ROTATION_STAGES+1];

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  pra_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (chain_v[0]),
    .cell_o  (chain[0])
  );

  for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cell
    pra_cell #(
      .STAGE (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_v[i]),
      .cell_i  (chain[i]),
      .valid_o (chain_v[i+1]),
      .cell_o  (chain[i+1])
    );
  end

  pra_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (chain_v[ROTATION_STAGES]),
    .cell_i  (chain[ROTATION_STAGES]),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

// ===== design/pra_checker.sv =====
`include "point_rotate_about_origin_core_macros.svh"

module pra_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input pra_pkg::out_t out_data_o
);
  import pra_pkg::*;

  // a stalled result stays put
  `PRA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // an empty output register never blocks requests
  `PRA_ASSERT_NOW(a_ready_when_empty, !out_valid_o, in_ready_o)

  // clipped only with a coordinate pinned at a rail
  `PRA_ASSERT_NOW(a_clip_rail, out_valid_o && out_data_o.clipped, out_data_o.rotated_x == 32'sh7FFFFFFF || out_data_o.rotated_x == -32'sh80000000 || out_data_o.rotated_y == 32'sh7FFFFFFF || out_data_o.rotated_y == -32'sh80000000)

  // the pipeline moves on whenever the result is taken
  `PRA_ASSERT_NOW(a_ready_on_take, out_valid_o && out_ready_i, in_ready_o || !in_valid_i)

endmodule

bind point_rotate_about_origin_core pra_checker u_pra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
